[sv/volume_ramp_gain_unit_macros.svh]
// Assertion macros shared by the volume ramp gain unit.
`ifndef VOLUME_RAMP_GAIN_UNIT_MACROS_SVH
`define VOLUME_RAMP_GAIN_UNIT_MACROS_SVH

// same-cycle implication
`define VRG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vrg_pkg.sv]
// Types, constants and helper functions of the volume ramp gain unit.
package vrg_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int VOL_W            = 15;
  localparam int LEN_W            = 13;
  localparam int POS_W            = 12;
  localparam int MAX_BLOCK_FRAMES = 4096;
  localparam int FPB_RESET        = 1024;
  localparam int FRAC_W           = 16;
  localparam int ACC_W            = 45;
  localparam int GAIN_W           = ACC_W - FRAC_W;
  localparam int PROD_W           = SAMPLE_W + GAIN_W;
  localparam int INC_W            = 32;
  localparam int QUO_W            = VOL_W + FRAC_W;
  localparam int DIV_STEPS        = QUO_W;
  localparam int DIV_CNT_W        = 5;
  localparam int GAIN_SHIFT       = 12;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO_MODE      = 1'b0,
    REG_FRAMES_PER_BLOCK = 1'b1
  } vrg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIV_END,
    S_MUL,
    S_OUT
  } vrg_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_end;
    logic mul;
    logic out;
  } vrg_cmd_t;

  typedef struct packed {
    logic block_start;
    logic div_last;
    logic out_free;
  } vrg_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    s  = p >>> GAIN_SHIFT;
    hi = PROD_W'(32767);
    lo = PROD_W'(-32768);
    if (s > hi) begin
      return SAMPLE_W'(32767);
    end else if (s < lo) begin
      return SAMPLE_W'(-32768);
    end else begin
      return s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

[sv/vrg_intf.sv]
// Channel interfaces: input frames, result words and register writes.
interface vrg_frame_if;
  import vrg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [VOL_W-1:0]           target_volume;
  modport source (output valid, output left_sample, output right_sample,
                  output target_volume, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input target_volume, output ready);
endinterface

interface vrg_result_if;
  import vrg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic signed [SAMPLE_W-1:0] gain_applied;
  logic                       block_end;
  modport source (output valid, output left_out, output right_out,
                  output gain_applied, output block_end, input ready);
  modport sink (input valid, input left_out, input right_out,
                input gain_applied, input block_end, output ready);
endinterface

interface vrg_cfg_if;
  import vrg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/vrg_ctrl.sv]
// Sequencing state machine of the volume ramp gain unit.
module vrg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vrg_pkg::vrg_status_t status,
  output vrg_pkg::vrg_cmd_t    cmd
);
  import vrg_pkg::*;

  vrg_state_t state;
  vrg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.block_start ? S_DIV : S_MUL;
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: state_next = S_MUL;
      S_MUL:     state_next = S_OUT;
      S_OUT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV:     cmd.div_step = 1'b1;
      S_DIV_END: cmd.div_end  = 1'b1;
      S_MUL:     cmd.mul      = 1'b1;
      S_OUT:     cmd.out      = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/vrg_dpath.sv]
// Ramp state, increment divider, gain multipliers and output register.
module vrg_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  vrg_pkg::vrg_cmd_t                   cmd,
  output vrg_pkg::vrg_status_t                status,
  input  logic                                cfg_valid,
  input  logic [vrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vrg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [vrg_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [vrg_pkg::SAMPLE_W-1:0] right_sample,
  input  logic [vrg_pkg::VOL_W-1:0]           target_volume,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [vrg_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [vrg_pkg::SAMPLE_W-1:0] right_out,
  output logic signed [vrg_pkg::SAMPLE_W-1:0] gain_applied,
  output logic                                block_end
);
  import vrg_pkg::*;

  logic                       stereo_mode;
  logic [LEN_W-1:0]           frames_per_block;
  logic [VOL_W-1:0]           prev_volume;
  logic signed [ACC_W-1:0]    acc;
  logic signed [INC_W-1:0]    inc;
  logic [POS_W-1:0]           pos;
  logic [LEN_W-1:0]           divisor;
  logic [LEN_W-1:0]           rem;
  logic [QUO_W-1:0]           quo;
  logic                       neg;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic signed [PROD_W-1:0]   prod_l;
  logic signed [PROD_W-1:0]   prod_r;

  logic [LEN_W-1:0]           len;
  logic signed [VOL_W:0]      diff;
  logic [VOL_W-1:0]           mag;
  logic [LEN_W:0]             rem_sh;
  logic [LEN_W:0]             rem_sub;
  logic                       rem_ge;
  logic signed [INC_W-1:0]    quo_ext;
  logic signed [GAIN_W-1:0]   gain;
  logic [LEN_W-1:0]           pos_inc;
  logic                       last;

  always_comb begin
    if (frames_per_block == '0) begin
      len = LEN_W'(1);
    end else if (frames_per_block > LEN_W'(MAX_BLOCK_FRAMES)) begin
      len = LEN_W'(MAX_BLOCK_FRAMES);
    end else begin
      len = frames_per_block;
    end
  end

  assign diff    = $signed({1'b0, target_volume}) - $signed({1'b0, prev_volume});
  assign mag     = diff[VOL_W] ? VOL_W'(-diff) : diff[VOL_W-1:0];
  assign rem_sh  = {rem, quo[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign quo_ext = $signed({1'b0, quo});
  assign gain    = acc[ACC_W-1:FRAC_W];
  assign pos_inc = {1'b0, pos} + LEN_W'(1);
  assign last    = pos_inc >= len;

  assign status.block_start = pos == '0;
  assign status.div_last    = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode      <= 1'b1;
      frames_per_block <= LEN_W'(FPB_RESET);
    end else if (cfg_valid) begin
      case (vrg_reg_t'(cfg_index))
        REG_STEREO_MODE:      stereo_mode      <= cfg_data[0];
        REG_FRAMES_PER_BLOCK: frames_per_block <= cfg_data;
        default:              stereo_mode      <= stereo_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_volume <= '0;
      pos         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load && status.block_start) begin
        prev_volume <= target_volume;
      end
      if (cmd.out) begin
        pos       <= last ? '0 : pos_inc[POS_W-1:0];
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_q  <= left_sample;
      right_q <= right_sample;
      if (status.block_start) begin
        acc     <= $signed(ACC_W'({prev_volume, FRAC_W'(0)}));
        divisor <= len;
        rem     <= '0;
        quo     <= {mag, FRAC_W'(0)};
        neg     <= diff[VOL_W];
        div_cnt <= '0;
      end
    end
    if (cmd.div_step) begin
      rem     <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      quo     <= {quo[QUO_W-2:0], rem_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.div_end) begin
      inc <= neg ? -quo_ext : quo_ext;
    end
    if (cmd.mul) begin
      prod_l <= left_q * gain;
      prod_r <= right_q * gain;
    end
    if (cmd.out) begin
      left_out     <= sat16(prod_l);
      right_out    <= stereo_mode ? sat16(prod_r) : '0;
      gain_applied <= gain[SAMPLE_W-1:0];
      block_end    <= last;
      acc          <= acc + ACC_W'(inc);
    end
  end

endmodule

[sv/volume_ramp_gain_unit.sv]
// Top level of the volume ramp gain unit.
// Each frame passes the multiply and output states; the output state waits until the
// result slot is free. A block's first frame before them runs the bit-serial increment
// divider (31 quotient bits, one per cycle, plus sign fix). Frames enter only in idle.
// Reset: state idle, previous volume 0, stereo mode on, block length 1024 frames.
module volume_ramp_gain_unit (
  input logic       clk,
  input logic       rst,
  vrg_frame_if.sink   frame,
  vrg_result_if.source result,
  vrg_cfg_if.sink     cfg
);
  import vrg_pkg::*;
  `include "volume_ramp_gain_unit_macros.svh"

  vrg_cmd_t    cmd;
  vrg_status_t status;

  assign cfg.ready = 1'b1;

  vrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (frame.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vrg_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .left_sample   (frame.left_sample),
    .right_sample  (frame.right_sample),
    .target_volume (frame.target_volume),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .left_out      (result.left_out),
    .right_out     (result.right_out),
    .gain_applied  (result.gain_applied),
    .block_end     (result.block_end)
  );

  `VRG_ASSERT_SAME(a_out_slot_free, clk, rst, cmd.out, !result.valid || result.ready, "result word overwritten")
  `VRG_ASSERT_NEXT(a_one_frame, clk, rst, frame.valid && frame.ready, !frame.ready, "second frame accepted while busy")
  `VRG_ASSERT_SAME(a_cmd_single, clk, rst, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule

[bench/volume_ramp_gain_unit_test.sv]
// Testbench of the volume ramp gain unit: ramp scoreboard, frame and register tasks, top.
module volume_ramp_gain_unit_test;
  import vrg_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_FRAMES = 1500;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_PHASE = 4;
  localparam int MAX_REPORTS = 10;
  localparam longint TIMEOUT = 64'd6_400_000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic signed [SAMPLE_W-1:0] gain_applied;
    logic                       block_end;
  } scaled_frame_t;

  class ramp_scoreboard;
    logic             stereo_on;
    logic [LEN_W-1:0] block_frames;
    logic [VOL_W-1:0] held_volume;
    longint           gain_acc;
    longint           gain_step;
    int unsigned      frame_index;
    scaled_frame_t    expected_frames[$];
    int               mismatches;

    function new();
      stereo_on = 1'b1;
      block_frames = LEN_W'(FPB_RESET);
      held_volume = '0;
      gain_acc = 0;
      gain_step = 0;
      frame_index = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_STEREO_MODE) begin
        stereo_on = data[0];
      end else if (idx == REG_FRAMES_PER_BLOCK) begin
        block_frames = data[LEN_W-1:0];
      end
    endfunction

    function logic signed [SAMPLE_W-1:0] apply_gain(longint sample, longint gain);
      longint scaled;
      scaled = (sample * gain) >>> GAIN_SHIFT;
      if (scaled > 32767) begin
        scaled = 32767;
      end else if (scaled < -32768) begin
        scaled = -32768;
      end
      return scaled[SAMPLE_W-1:0];
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right,
                             logic [VOL_W-1:0] target);
      scaled_frame_t word;
      longint        ramp_len;
      longint        gain;
      ramp_len = longint'(block_frames);
      if (ramp_len < 1) begin
        ramp_len = 1;
      end else if (ramp_len > MAX_BLOCK_FRAMES) begin
        ramp_len = MAX_BLOCK_FRAMES;
      end
      if (frame_index == 0) begin
        gain_step = ((longint'(target) - longint'(held_volume)) * 65536) / ramp_len;
        gain_acc = longint'(held_volume) * 65536;
        held_volume = target;
      end
      gain = gain_acc >>> FRAC_W;
      word.left_out = apply_gain(left, gain);
      word.right_out = stereo_on ? apply_gain(right, gain) : '0;
      word.gain_applied = gain[SAMPLE_W-1:0];
      gain_acc += gain_step;
      frame_index++;
      word.block_end = (longint'(frame_index) >= ramp_len);
      if (word.block_end) begin
        frame_index = 0;
      end
      expected_frames.push_back(word);
    endfunction

    function void compare_field(string field, logic signed [SAMPLE_W:0] want,
                                logic signed [SAMPLE_W:0] got);
      if (want === got) begin
        return;
      end
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right,
                               logic signed [SAMPLE_W-1:0] gain, logic block_end);
      scaled_frame_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result word with nothing expected: left %0d right %0d gain %0d end %0b",
                   left, right, gain, block_end);
        end
        return;
      end
      want = expected_frames.pop_front();
      compare_field("left_out", want.left_out, left);
      compare_field("right_out", want.right_out, right);
      compare_field("gain_applied", want.gain_applied, gain);
      compare_field("block_end", want.block_end, block_end);
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic hold_off;
  int unsigned rx_stall_pct;
  int unsigned tx_idle_pct;
  int unsigned random_frames;

  ramp_scoreboard board = new();

  vrg_frame_if  frame_bus();
  vrg_result_if result_bus();
  vrg_cfg_if    cfg_bus();

  volume_ramp_gain_unit dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst || hold_off) begin
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        board.write_reg(cfg_bus.index, cfg_bus.data);
      end
      if (frame_bus.valid && frame_bus.ready) begin
        board.note_frame(frame_bus.left_sample, frame_bus.right_sample, frame_bus.target_volume);
      end
      if (result_bus.valid && result_bus.ready) begin
        board.check_result(result_bus.left_out, result_bus.right_out, result_bus.gain_applied,
                           result_bus.block_end);
      end
    end
  end

  task automatic send_frame(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right,
                            logic [VOL_W-1:0] target);
    while ($urandom_range(99) < tx_idle_pct) begin
      frame_bus.valid <= 1'b0;
      @(posedge clk);
    end
    frame_bus.valid <= 1'b1;
    frame_bus.left_sample <= left;
    frame_bus.right_sample <= right;
    frame_bus.target_volume <= target;
    do @(posedge clk); while (!frame_bus.ready);
  endtask

  task automatic drain();
    frame_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // write both registers back to back; upper bits of the mode word are don't-care
  task automatic configure(logic stereo, logic [CFG_DATA_W-1:0] ramp_frames);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom);
    mode_word[0] = stereo;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_STEREO_MODE;
    cfg_bus.data <= mode_word;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= REG_FRAMES_PER_BLOCK;
    cfg_bus.data <= ramp_frames;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] pick_target();
    case ($urandom_range(9))
      0: return '0;
      1: return 15'h7FFF;
      2, 3: return 15'd4096;
      default: return VOL_W'($urandom_range(32767));
    endcase
  endfunction

  // mostly short ramps; zero and oversize lengths exercise the clamp
  function automatic logic [CFG_DATA_W-1:0] pick_ramp_frames();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 6) return 13'h1FFF;
    if (roll < 7) return CFG_DATA_W'($urandom_range(4097, 8190));
    if (roll < 9) return CFG_DATA_W'(MAX_BLOCK_FRAMES);
    if (roll < 30) return 13'd1;
    if (roll < 80) return CFG_DATA_W'($urandom_range(2, 12));
    return CFG_DATA_W'($urandom_range(13, 200));
  endfunction

  initial begin
    idle_mode_t  mode;
    int unsigned phase;
    int unsigned burst;
    rst <= 1'b1;
    hold_off <= 1'b0;
    rx_stall_pct <= 0;
    tx_idle_pct = 0;
    random_frames = 0;
    frame_bus.valid <= 1'b0;
    frame_bus.left_sample <= '0;
    frame_bus.right_sample <= '0;
    frame_bus.target_volume <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_STEREO_MODE;
    cfg_bus.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stereo, 1024-frame ramp from zero gain
    send_frame(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_frame(16'sh8000, 16'sh7FFF, 15'h0000);
    drain();
    // zero length clamps to one; shrinking ends the open ramp on the next frame
    configure(1'b1, 13'd0);
    send_frame(16'sd20000, -16'sd20000, 15'd1);
    send_frame(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_frame(16'sh8000, 16'sh7FFF, 15'd4096);
    send_frame(16'sd1000, -16'sd1000, 15'h0000);
    send_frame(16'sd0, 16'sd0, 15'h7FFF);
    drain();
    // mono, ramp down, then lengthen mid-ramp so the gain overshoots below zero
    configure(1'b0, 13'd2);
    send_frame(16'sh8000, 16'sh7FFF, 15'h0000);
    drain();
    configure(1'b1, 13'd8);
    repeat (7) send_frame(pick_sample(), pick_sample(), pick_target());
    drain();
    // oversize length clamps to the maximum
    configure(1'b1, 13'h1FFF);
    send_frame(16'sd1234, -16'sd4321, 15'd4096);
    send_frame(16'sh7FFF, 16'sh8000, 15'h7FFF);
    drain();
    configure(1'b1, 13'd1);
    send_frame(-16'sd1, 16'sd1, 15'h2AAA);

    phase = 0;
    while (random_frames < RANDOM_FRAMES) begin
      drain();
      configure(1'($urandom), pick_ramp_frames());
      mode = idle_mode_t'(phase % 4);
      case (mode)
        IDLE_NONE: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        IDLE_SENDER: begin
          tx_idle_pct = 56;
          rx_stall_pct <= 0;
        end
        IDLE_RECEIVER: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 56;
        end
        default: begin
          tx_idle_pct = 18;
          rx_stall_pct <= 18;
        end
      endcase
      if (phase == HOLD_OFF_PHASE) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      burst = $urandom_range(40, 120);
      repeat (burst) begin
        send_frame(pick_sample(), pick_sample(), pick_target());
        random_frames++;
      end
      phase++;
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("volume_ramp_gain_unit verification clean");
    end else begin
      $display("volume_ramp_gain_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("volume_ramp_gain_unit verification failed");
    $finish;
  end

endmodule
